/* design/step_shoot_step_sequencer_assert.svh */
// Assertion macros used by the sequencer checker.
`ifndef STEP_SHOOT_STEP_SEQUENCER_ASSERT_SVH
`define STEP_SHOOT_STEP_SEQUENCER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define SSSQ_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A condition on one edge requires a condition on the next edge.
`define SSSQ_CHECK_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

/* design/sssq_pkg.sv */
// Shared types, codes and constants of the step-shoot-step sequencer.
package sssq_pkg;

	localparam int TICKS_PER_SECOND_DEF = 1000;
	localparam int HALF_STEP_TICKS_DEF  = 50;

	localparam int IN_W  = 8;
	localparam int OUT_W = 24;
	localparam int CFG_W = 16;

	localparam logic [15:0] STEPS_RST = 16'd1;
	localparam logic [15:0] RELAY_RST = 16'd100;

	typedef enum logic [2:0] {
		CFG_MICROSTEP = 3'd0,
		CFG_START_DIR = 3'd1,
		CFG_STARTUP   = 3'd2,
		CFG_STEPS     = 3'd3,
		CFG_SETTLE    = 3'd4,
		CFG_RELAY     = 3'd5,
		CFG_POST      = 3'd6
	} cfg_idx_t;

	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_STEP   = 5'b00010,
		PH_SETTLE = 5'b00100,
		PH_TRIG   = 5'b01000,
		PH_POST   = 5'b10000
	} phase_t;

	localparam logic [2:0] PCODE_START  = 3'd0;
	localparam logic [2:0] PCODE_STEP   = 3'd1;
	localparam logic [2:0] PCODE_SETTLE = 3'd2;
	localparam logic [2:0] PCODE_TRIG   = 3'd3;
	localparam logic [2:0] PCODE_POST   = 3'd4;

	typedef struct packed {
		logic        microstep_on;
		logic        start_direction;
		logic [7:0]  startup_seconds;
		logic [15:0] steps_per_cycle;
		logic [7:0]  settle_seconds;
		logic [15:0] relay_millis;
		logic [7:0]  post_seconds;
	} cfg_t;

	// field order matches the output tdata packing, lowest bit last here
	typedef struct packed {
		logic [2:0]  phase_now;
		logic [15:0] shots_taken;
		logic        half_step_mode;
		logic        relay_level;
		logic        dir_level;
		logic        step_level;
	} res_t;

	function automatic logic [2:0] phase_code(phase_t p);
		logic [2:0] c;
		case (p)
			PH_START:  c = PCODE_START;
			PH_STEP:   c = PCODE_STEP;
			PH_SETTLE: c = PCODE_SETTLE;
			PH_TRIG:   c = PCODE_TRIG;
			PH_POST:   c = PCODE_POST;
			default:   c = PCODE_POST;
		endcase
		return c;
	endfunction

endpackage

/* design/sssq_core.sv */
// Tick sequencer: phase state, counters and the per-tick update.
module sssq_core import sssq_pkg::*; #(
	parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
	parameter int HALF_STEP_TICKS  = HALF_STEP_TICKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic run,
	input  logic left_clear,
	input  logic right_clear,
	input  cfg_t cfg,
	output res_t res
);

	localparam int FULL_TICKS = 2 * HALF_STEP_TICKS;
	localparam int MAX_A   = (TICKS_PER_SECOND > FULL_TICKS) ? TICKS_PER_SECOND : FULL_TICKS;
	localparam int CNT_MAX = (MAX_A > 65535) ? MAX_A : 65535;
	localparam int CW      = $clog2(CNT_MAX + 1);
	// worst chain in one tick: startup, a full cycle of empty parts, up to the post wait
	localparam int CHAIN   = 9;

	phase_t        ph_q, ph_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW:0]   cnt_inc;
	logic [7:0]    sec_q, sec_d;
	logic [15:0]   pul_q, pul_d;
	logic [15:0]   shots_q, shots_d;
	logic          dir_q, dir_d;
	logic          mode_q, mode_d;
	logic          step_q, step_d;
	logic          relay_q, relay_d;
	logic          started, busy, sec_tick;

	always_comb begin
		ph_d     = ph_q;
		cnt_d    = cnt_q;
		sec_d    = sec_q;
		pul_d    = pul_q;
		shots_d  = shots_q;
		dir_d    = dir_q;
		mode_d   = mode_q;
		step_d   = step_q;
		relay_d  = relay_q;
		started  = 1'b0;
		busy     = 1'b0;
		sec_tick = 1'b0;
		cnt_inc  = '0;
		if (run) begin
			step_d  = 1'b0;
			relay_d = 1'b0;
			if (ph_q == PH_START && cnt_q == '0 && sec_q == '0) begin
				mode_d = cfg.microstep_on;
				dir_d  = cfg.start_direction;
			end
			busy = 1'b1;
			for (int i = 0; i < CHAIN; i++) begin
				if (busy) begin
					case (ph_d)
						PH_START: begin
							if (sec_d >= cfg.startup_seconds) begin
								if (!left_clear) dir_d = 1'b0;
								else if (!right_clear) dir_d = 1'b1;
								ph_d    = PH_STEP;
								cnt_d   = '0;
								sec_d   = '0;
								pul_d   = '0;
								started = 1'b1;
							end else begin
								sec_tick = 1'b1;
								busy     = 1'b0;
							end
						end
						PH_STEP: begin
							if (pul_d >= cfg.steps_per_cycle) begin
								ph_d  = PH_SETTLE;
								cnt_d = '0;
								sec_d = '0;
							end else begin
								step_d  = (cnt_d >= CW'(HALF_STEP_TICKS));
								cnt_inc = {1'b0, cnt_d} + (CW+1)'(1);
								if (cnt_inc >= (CW+1)'(FULL_TICKS)) begin
									cnt_d = '0;
									pul_d = pul_d + 16'd1;
								end else begin
									cnt_d = cnt_inc[CW-1:0];
								end
								busy = 1'b0;
							end
						end
						PH_SETTLE: begin
							if (sec_d >= cfg.settle_seconds) begin
								ph_d  = PH_TRIG;
								cnt_d = '0;
								sec_d = '0;
							end else begin
								sec_tick = 1'b1;
								busy     = 1'b0;
							end
						end
						PH_TRIG: begin
							if (cnt_d >= CW'(cfg.relay_millis)) begin
								shots_d = shots_d + 16'd1;
								ph_d    = PH_POST;
								cnt_d   = '0;
								sec_d   = '0;
							end else begin
								relay_d = 1'b1;
								cnt_d   = cnt_d + CW'(1);
								busy    = 1'b0;
							end
						end
						PH_POST: begin
							if (sec_d >= cfg.post_seconds) begin
								// at most one cycle start per tick
								if (started) begin
									busy = 1'b0;
								end else begin
									if (!left_clear) dir_d = 1'b0;
									else if (!right_clear) dir_d = 1'b1;
									ph_d    = PH_STEP;
									cnt_d   = '0;
									sec_d   = '0;
									pul_d   = '0;
									started = 1'b1;
								end
							end else begin
								sec_tick = 1'b1;
								busy     = 1'b0;
							end
						end
						default: begin
							ph_d = PH_POST;
							busy = 1'b0;
						end
					endcase
				end
			end
			// one tick of a seconds wait: ms counter rolls into the seconds count
			if (sec_tick) begin
				cnt_inc = {1'b0, cnt_d} + (CW+1)'(1);
				if (cnt_inc == (CW+1)'(TICKS_PER_SECOND)) begin
					cnt_d = '0;
					sec_d = sec_d + 8'd1;
				end else begin
					cnt_d = cnt_inc[CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_START;
			cnt_q   <= '0;
			sec_q   <= '0;
			pul_q   <= '0;
			shots_q <= '0;
			dir_q   <= 1'b0;
			mode_q  <= 1'b0;
			step_q  <= 1'b0;
			relay_q <= 1'b0;
		end else if (adv) begin
			ph_q    <= ph_d;
			cnt_q   <= cnt_d;
			sec_q   <= sec_d;
			pul_q   <= pul_d;
			shots_q <= shots_d;
			dir_q   <= dir_d;
			mode_q  <= mode_d;
			step_q  <= step_d;
			relay_q <= relay_d;
		end
	end

	assign res.step_level     = step_d;
	assign res.dir_level      = dir_d;
	assign res.relay_level    = relay_d;
	assign res.half_step_mode = mode_d;
	assign res.shots_taken    = shots_d;
	assign res.phase_now      = phase_code(ph_d);

endmodule

/* design/step_shoot_step_sequencer.sv */
// Channel  | Dir | Handshake          | Contents
// s        | in  | s_tvalid/s_tready  | one tick: run, endstop levels
// m        | out | m_tvalid/m_tready  | levels, shot count and phase after the tick
// cfg      | in  | cfg_we             | register writes by index
//
// One item per clock cycle while the receiver takes results; an item passes through the input
// register and the combinational tick update into the result register.
// Reset clears all sequence state and loads the register reset values.
// A stalled result holds in the output register; the input register takes one more item
// only if it is empty, after which s_tready drops until the result is taken.
module step_shoot_step_sequencer import sssq_pkg::*; #(
	parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
	parameter int HALF_STEP_TICKS  = HALF_STEP_TICKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // run, left_stop_clear, right_stop_clear, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // step_level, dir_level, relay_level,
	                                   // half_step_mode, shots_taken[15:0],
	                                   // phase_now[2:0], zero pad
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       run_s1, left_s1, right_s1;
	logic       m_valid_q;
	res_t       m_data_q;
	res_t       res;
	logic       adv;

	assign adv      = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.microstep_on    <= 1'b0;
			cfg_q.start_direction <= 1'b0;
			cfg_q.startup_seconds <= '0;
			cfg_q.steps_per_cycle <= STEPS_RST;
			cfg_q.settle_seconds  <= '0;
			cfg_q.relay_millis    <= RELAY_RST;
			cfg_q.post_seconds    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MICROSTEP: cfg_q.microstep_on    <= cfg_wdata[0];
				CFG_START_DIR: cfg_q.start_direction <= cfg_wdata[0];
				CFG_STARTUP:   cfg_q.startup_seconds <= cfg_wdata[7:0];
				CFG_STEPS:     cfg_q.steps_per_cycle <= cfg_wdata;
				CFG_SETTLE:    cfg_q.settle_seconds  <= cfg_wdata[7:0];
				CFG_RELAY:     cfg_q.relay_millis    <= cfg_wdata;
				CFG_POST:      cfg_q.post_seconds    <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (adv) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			run_s1   <= s_tdata[0];
			left_s1  <= s_tdata[1];
			right_s1 <= s_tdata[2];
		end
		if (adv) m_data_q <= res;
	end

	sssq_core #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND),
		.HALF_STEP_TICKS  (HALF_STEP_TICKS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.run         (run_s1),
		.left_clear  (left_s1),
		.right_clear (right_s1),
		.cfg         (cfg_q),
		.res         (res)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_data_q};

endmodule

/* design/sssq_checker.sv */
// Port-level checks on the sequencer result stream, bound to the top level.
`include "step_shoot_step_sequencer_assert.svh"

module sssq_checker import sssq_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	`SSSQ_CHECK(a_phase_code, (m_tvalid |-> (m_tdata[22:20] <= PCODE_POST)), "phase code out of range")
	`SSSQ_CHECK(a_relay_phase, ((m_tvalid && m_tdata[2]) |-> (m_tdata[22:20] == PCODE_TRIG)), "relay high outside trigger")
	`SSSQ_CHECK(a_step_phase, ((m_tvalid && m_tdata[0]) |-> (m_tdata[22:20] == PCODE_STEP)), "step high outside stepping")
	`SSSQ_CHECK_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind step_shoot_step_sequencer sssq_checker u_sssq_checker (.*);

/* test/testbench.sv */
// Self-checking testbench for the step-shoot-step time-lapse sequencer.
module testbench;
	import sssq_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [2:0]       cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	step_shoot_step_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #4 clk = ~clk;

	// sequencer shadow: registers, phase and counters
	logic [15:0] reg_file [7];
	logic [2:0]  seq_phase;
	int unsigned elapsed;
	logic [15:0] pulse_count;
	logic        dir_q;
	logic        mode_q;
	logic [15:0] shot_q;
	logic        step_q;
	logic        relay_q;

	res_t levels_due [$];
	int   err_count   = 0;
	int   quiet_count = 0;
	int   hold_left   = 0;
	bit   gaps_on     = 1'b1;

	task automatic shadow_reset();
		for (int i = 0; i < 7; i++)
			reg_file[i] = '0;
		reg_file[CFG_STEPS] = STEPS_RST;
		reg_file[CFG_RELAY] = RELAY_RST;
		seq_phase   = PCODE_START;
		elapsed     = 0;
		pulse_count = '0;
		dir_q       = 1'b0;
		mode_q      = 1'b0;
		shot_q      = '0;
		step_q      = 1'b0;
		relay_q     = 1'b0;
	endtask

	task automatic begin_cycle(bit left_clear, bit right_clear);
		// left endstop wins when both are hit
		if (!left_clear)
			dir_q = 1'b0;
		else if (!right_clear)
			dir_q = 1'b1;
		seq_phase   = PCODE_STEP;
		elapsed     = 0;
		pulse_count = '0;
	endtask

	task automatic seq_advance(bit left_clear, bit right_clear);
		bit          started;
		bit          done;
		int unsigned span;
		started = 1'b0;
		done    = 1'b0;
		step_q  = 1'b0;
		relay_q = 1'b0;
		if (seq_phase == PCODE_START && elapsed == 0) begin
			mode_q = reg_file[CFG_MICROSTEP][0];
			dir_q  = reg_file[CFG_START_DIR][0];
		end
		// zero-length parts fall through within the same tick
		while (!done) begin
			case (seq_phase)
				PCODE_START: begin
					span = 32'(reg_file[CFG_STARTUP]) * TICKS_PER_SECOND_DEF;
					if (elapsed >= span) begin
						begin_cycle(left_clear, right_clear);
						started = 1'b1;
					end else begin
						elapsed++;
						done = 1'b1;
					end
				end
				PCODE_STEP: begin
					if (pulse_count >= reg_file[CFG_STEPS]) begin
						seq_phase = PCODE_SETTLE;
						elapsed   = 0;
					end else begin
						step_q = (elapsed < HALF_STEP_TICKS_DEF) ? 1'b0 : 1'b1;
						elapsed++;
						if (elapsed >= 2 * HALF_STEP_TICKS_DEF) begin
							elapsed     = 0;
							pulse_count = pulse_count + 16'd1;
						end
						done = 1'b1;
					end
				end
				PCODE_SETTLE: begin
					span = 32'(reg_file[CFG_SETTLE]) * TICKS_PER_SECOND_DEF;
					if (elapsed >= span) begin
						seq_phase = PCODE_TRIG;
						elapsed   = 0;
					end else begin
						elapsed++;
						done = 1'b1;
					end
				end
				PCODE_TRIG: begin
					if (elapsed >= 32'(reg_file[CFG_RELAY])) begin
						shot_q    = shot_q + 16'd1;
						seq_phase = PCODE_POST;
						elapsed   = 0;
					end else begin
						relay_q = 1'b1;
						elapsed++;
						done = 1'b1;
					end
				end
				default: begin
					seq_phase = PCODE_POST;
					span = 32'(reg_file[CFG_POST]) * TICKS_PER_SECOND_DEF;
					if (elapsed >= span) begin
						// only one cycle may start per tick
						if (started) begin
							done = 1'b1;
						end else begin
							begin_cycle(left_clear, right_clear);
							started = 1'b1;
						end
					end else begin
						elapsed++;
						done = 1'b1;
					end
				end
			endcase
		end
	endtask

	function automatic res_t shown_levels();
		res_t r;
		r.step_level     = step_q;
		r.dir_level      = dir_q;
		r.relay_level    = relay_q;
		r.half_step_mode = mode_q;
		r.shots_taken    = shot_q;
		r.phase_now      = seq_phase;
		return r;
	endfunction

	task automatic write_reg(cfg_idx_t idx, int unsigned value);
		logic [15:0] mask;
		case (idx)
			CFG_MICROSTEP, CFG_START_DIR:      mask = 16'h0001;
			CFG_STARTUP, CFG_SETTLE, CFG_POST: mask = 16'h00FF;
			default:                           mask = 16'hFFFF;
		endcase
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = value[15:0];
		@(negedge clk);
		cfg_we = 1'b0;
		reg_file[idx] = value[15:0] & mask;
	endtask

	// leaves s_tvalid high so back-to-back ticks follow without a gap unless gaps_on adds one
	task automatic send_tick(bit run, bit left_clear, bit right_clear);
		while (gaps_on && $urandom_range(99) < 18) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {5'b0, right_clear, left_clear, run};
		do @(posedge clk); while (!s_tready);
		if (run)
			seq_advance(left_clear, right_clear);
		levels_due.push_back(shown_levels());
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (levels_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic bit endstop_level();
		return $urandom_range(99) >= 15;
	endfunction

	function automatic int unsigned pick_seconds();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 80)
			return 0;
		if (r < 95)
			return 1;
		return 255;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[$bits(res_t)-1:0]);
			if (levels_due.size() == 0) begin
				$error("result transaction with no tick pending");
				err_count++;
			end else begin
				want = levels_due.pop_front();
				check_field("step_level", want.step_level, got.step_level);
				check_field("dir_level", want.dir_level, got.dir_level);
				check_field("relay_level", want.relay_level, got.relay_level);
				check_field("half_step_mode", want.half_step_mode, got.half_step_mode);
				check_field("shots_taken", want.shots_taken, got.shots_taken);
				check_field("phase_now", want.phase_now, got.phase_now);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready  = 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready = !(gaps_on && $urandom_range(99) < 18);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_count = 0;
			else
				quiet_count++;
			if (quiet_count >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// mode and start direction are latched by the first run tick only
	task automatic test_first_tick_latch();
		write_reg(CFG_MICROSTEP, 1);
		write_reg(CFG_START_DIR, 1);
		write_reg(CFG_STARTUP, 255);
		write_reg(CFG_STEPS, 1);
		write_reg(CFG_SETTLE, 0);
		write_reg(CFG_RELAY, 2);
		write_reg(CFG_POST, 0);
		send_tick(0, 1, 1);
		send_tick(1, 1, 1);
		send_tick(1, 0, 0);
		send_tick(1, 1, 1);
		drain();
		// a shortened startup keeps waiting while short of it; a zero startup then ends it at once
		write_reg(CFG_STARTUP, 1);
		send_tick(1, 1, 1);
		send_tick(0, 0, 1);
		drain();
		write_reg(CFG_STARTUP, 0);
		send_tick(1, 1, 1);
		send_tick(1, 1, 1);
		drain();
	endtask

	// one-tick cycles so every tick samples the endstops
	task automatic test_endstop_priority();
		write_reg(CFG_MICROSTEP, 0);
		write_reg(CFG_START_DIR, 0);
		write_reg(CFG_STEPS, 0);
		write_reg(CFG_RELAY, 1);
		write_reg(CFG_SETTLE, 0);
		write_reg(CFG_POST, 0);
		send_tick(1, 1, 1);
		send_tick(1, 0, 1);
		send_tick(1, 1, 0);
		send_tick(1, 0, 0);
		send_tick(1, 1, 1);
		send_tick(1, 1, 0);
		send_tick(0, 0, 0);
		send_tick(1, 0, 1);
		drain();
	endtask

	task automatic test_zero_length_parts();
		// all parts empty: a shot per tick, relay never high
		write_reg(CFG_RELAY, 0);
		send_tick(1, 1, 1);
		send_tick(1, 0, 0);
		send_tick(1, 1, 0);
		drain();
		write_reg(CFG_STEPS, 65535);
		write_reg(CFG_RELAY, 65535);
		write_reg(CFG_SETTLE, 255);
		send_tick(1, 1, 1);
		send_tick(1, 1, 1);
		drain();
		write_reg(CFG_STEPS, 0);
		send_tick(1, 1, 1);
		send_tick(1, 1, 1);
		drain();
		write_reg(CFG_SETTLE, 0);
		send_tick(1, 1, 1);
		send_tick(1, 1, 1);
		drain();
		write_reg(CFG_RELAY, 0);
		write_reg(CFG_POST, 255);
		send_tick(1, 1, 1);
		send_tick(1, 0, 1);
		drain();
		write_reg(CFG_POST, 0);
		send_tick(1, 0, 1);
		drain();
	endtask

	task automatic test_random_cycles();
		for (int round = 0; round < 12; round++) begin
			write_reg(CFG_MICROSTEP, $urandom_range(1));
			write_reg(CFG_START_DIR, $urandom_range(1));
			write_reg(CFG_STARTUP, pick_seconds());
			write_reg(CFG_STEPS, ($urandom_range(99) < 85) ?
				$urandom_range(2) : $urandom_range(65535));
			write_reg(CFG_SETTLE, pick_seconds());
			write_reg(CFG_RELAY, ($urandom_range(99) < 85) ?
				$urandom_range(40) : $urandom_range(65535));
			write_reg(CFG_POST, pick_seconds());
			// a few rounds run at full rate on both sides
			gaps_on = !(round >= 4 && round <= 6);
			for (int n = 0; n < 40; n++)
				send_tick($urandom_range(99) < 90, endstop_level(), endstop_level());
			drain();
		end
		gaps_on = 1'b1;
	endtask

	// receiver stalls long enough for the block to fill and push back
	task automatic test_backpressure();
		write_reg(CFG_STEPS, 1);
		write_reg(CFG_RELAY, 5);
		write_reg(CFG_SETTLE, 0);
		write_reg(CFG_POST, 0);
		hold_left = HOLD_CYCLES;
		for (int n = 0; n < 40; n++)
			send_tick(1'b1, endstop_level(), endstop_level());
		drain();
	endtask

	initial begin
		shadow_reset();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_first_tick_latch();
		test_endstop_priority();
		test_zero_length_parts();
		test_random_cycles();
		test_backpressure();
		repeat (10) @(negedge clk);
		if (err_count == 0 && levels_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* step_shoot_step_sequencer.f */
+incdir+design
design/sssq_pkg.sv
design/sssq_core.sv
design/step_shoot_step_sequencer.sv
design/sssq_checker.sv
test/testbench.sv
